// File: hdl/detection_row_decode_core_defines.svh
// Assertion macros shared by the checkers of the detection row decoder.
// No dependencies; take it in with an include of the bare file name.
`ifndef DETECTION_ROW_DECODE_CORE_DEFINES_SVH
`define DETECTION_ROW_DECODE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DRD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("Same-cycle implication failed.");

// Next-cycle implication, disabled while reset is asserted.
`define DRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("Next-cycle implication failed.");

`endif

// File: hdl/drd_pkg.sv
// Shared types and constants of the detection row decoder.
// No dependencies; used by every module of the block.
package drd_pkg;

  localparam int MaxClasses = 255;
  localparam int ValueW = 16;
  localparam int ClassW = 8;
  localparam int PosW = 9;
  localparam int ScaleW = 5;
  localparam int CfgIdxW = 3;
  localparam int QueueDepth = 2;
  localparam int QueuePtrW = $clog2(QueueDepth);
  localparam int QueueCntW = $clog2(QueueDepth + 1);

  localparam logic [CfgIdxW-1:0] RegObjMode = 3'd0;
  localparam logic [CfgIdxW-1:0] RegNumClasses = 3'd1;
  localparam logic [CfgIdxW-1:0] RegScoreThr = 3'd2;
  localparam logic [CfgIdxW-1:0] RegConfThr = 3'd3;
  localparam logic [CfgIdxW-1:0] RegXScale = 3'd4;
  localparam logic [CfgIdxW-1:0] RegYScale = 3'd5;

  typedef struct packed {
    logic              obj_mode;
    logic [ClassW-1:0] num_classes;
    logic [ValueW-1:0] score_thr;
    logic [ValueW-1:0] conf_thr;
  } front_cfg_t;

  typedef struct packed {
    logic [ScaleW-1:0] x_scale;
    logic [ScaleW-1:0] y_scale;
  } scale_cfg_t;

  typedef struct packed {
    logic [ClassW-1:0] class_index;
    logic [ValueW-1:0] confidence;
    logic [ValueW-1:0] x;
    logic [ValueW-1:0] y;
    logic [ValueW-1:0] w;
    logic [ValueW-1:0] h;
  } det_t;

endpackage

// File: hdl/detection_row_decode_core.sv
// Top level of the detection row decoder: configuration registers and wiring.
// Instantiates drd_front, drd_queue and drd_back; uses drd_pkg.
//
//   Channel   Direction   Handshake                Payload
//   in        sink        in_valid_i / in_stall_o   in_element_value_i
//   out       source      out_valid_o / out_stall_i class, confidence, box edges
//   cfg       sink        cfg_we_i                  cfg_index_i, cfg_wdata_i
//
// One element is taken per cycle; the front end stalls only while the
// two-entry detection queue is full.
// A detection passes through the detection queue, the first scaler stage and
// the result register before it is valid at the output.
// Reset clears the row position, the argmax, the queue and all valid flags.
// An output stall backs up into the queue and then into the input.
module detection_row_decode_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [drd_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [drd_pkg::ValueW-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [drd_pkg::ValueW-1:0]        in_element_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [drd_pkg::ClassW-1:0]        out_class_index_o,
  output logic [drd_pkg::ValueW-1:0]        out_confidence_o,
  output logic signed [drd_pkg::ValueW:0]   out_box_left_o,
  output logic signed [drd_pkg::ValueW:0]   out_box_top_o,
  output logic [drd_pkg::ValueW-1:0]        out_box_width_o,
  output logic [drd_pkg::ValueW-1:0]        out_box_height_o
);
  import drd_pkg::*;

  front_cfg_t front_cfg_q;
  scale_cfg_t scale_cfg_q;
  logic       push, full, q_valid, pop;
  det_t       push_data, q_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_cfg_q.obj_mode <= 1'b0;
      front_cfg_q.num_classes <= ClassW'(80);
      front_cfg_q.score_thr <= ValueW'(32768);
      front_cfg_q.conf_thr <= ValueW'(32768);
      scale_cfg_q.x_scale <= ScaleW'(1);
      scale_cfg_q.y_scale <= ScaleW'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegObjMode: begin
          front_cfg_q.obj_mode <= cfg_wdata_i[0];
        end
        RegNumClasses: begin
          front_cfg_q.num_classes <= cfg_wdata_i[ClassW-1:0];
        end
        RegScoreThr: begin
          front_cfg_q.score_thr <= cfg_wdata_i;
        end
        RegConfThr: begin
          front_cfg_q.conf_thr <= cfg_wdata_i;
        end
        RegXScale: begin
          scale_cfg_q.x_scale <= cfg_wdata_i[ScaleW-1:0];
        end
        RegYScale: begin
          scale_cfg_q.y_scale <= cfg_wdata_i[ScaleW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  drd_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (front_cfg_q),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .in_element_value_i(in_element_value_i),
    .full_i            (full),
    .push_o            (push),
    .push_data_o       (push_data)
  );

  drd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (full),
    .valid_o    (q_valid),
    .pop_data_o (q_data),
    .pop_i      (pop)
  );

  drd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .scale_i          (scale_cfg_q),
    .q_valid_i        (q_valid),
    .q_data_i         (q_data),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_class_index_o(out_class_index_o),
    .out_confidence_o (out_confidence_o),
    .out_box_left_o   (out_box_left_o),
    .out_box_top_o    (out_box_top_o),
    .out_box_width_o  (out_box_width_o),
    .out_box_height_o (out_box_height_o)
  );

endmodule

// File: hdl/drd_front.sv
// Front end: accepts tensor elements, tracks the row position and the argmax.
// Pushes a raw detection into the queue at a passing row end. Uses drd_pkg.
module drd_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  drd_pkg::front_cfg_t       cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [drd_pkg::ValueW-1:0] in_element_value_i,
  input  logic                      full_i,
  output logic                      push_o,
  output drd_pkg::det_t             push_data_o
);
  import drd_pkg::*;

  logic [PosW-1:0]   pos_q, pos_d;
  logic [ValueW-1:0] best_q, best_d;
  logic [ClassW-1:0] class_q, class_d;
  logic [ValueW-1:0] box_q [4];
  logic [ValueW-1:0] obj_q;

  logic              accept;
  logic [ClassW-1:0] n_eff, last_k, k;
  logic [PosW-1:0]   first, k_raw;
  logic              is_box, is_obj, is_cls, upd, row_end, pass;

  assign in_stall_o = full_i;
  assign accept = in_valid_i && !full_i;

  always_comb begin
    n_eff = (cfg_i.num_classes == '0) ? ClassW'(1) : cfg_i.num_classes;
    if (int'(n_eff) > MaxClasses) begin
      n_eff = ClassW'(MaxClasses);
    end
    last_k = n_eff - ClassW'(1);
    first = PosW'(4) + PosW'(cfg_i.obj_mode);
    k_raw = pos_q - first;
    k = (k_raw > {1'b0, last_k}) ? last_k : k_raw[ClassW-1:0];
    is_box = pos_q < PosW'(4);
    is_obj = !is_box && (pos_q < first);
    is_cls = !is_box && !is_obj;
    upd = (k == '0) || (in_element_value_i > best_q);
    best_d = best_q;
    class_d = class_q;
    pos_d = pos_q;
    if (accept && is_cls && upd) begin
      best_d = in_element_value_i;
      class_d = k;
    end
    row_end = is_cls && (k == last_k);
    if (accept) begin
      pos_d = row_end ? '0 : pos_q + PosW'(1);
    end
    pass = (best_d > cfg_i.score_thr) && !(cfg_i.obj_mode && (obj_q < cfg_i.conf_thr));
  end

  assign push_o = accept && row_end && pass;
  assign push_data_o.class_index = class_d;
  assign push_data_o.confidence = cfg_i.obj_mode ? obj_q : best_d;
  assign push_data_o.x = box_q[0];
  assign push_data_o.y = box_q[1];
  assign push_data_o.w = box_q[2];
  assign push_data_o.h = box_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      best_q <= '0;
      class_q <= '0;
    end else begin
      pos_q <= pos_d;
      best_q <= best_d;
      class_q <= class_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_box) begin
      box_q[pos_q[1:0]] <= in_element_value_i;
    end
    if (accept && is_obj) begin
      obj_q <= in_element_value_i;
    end
  end

endmodule

// File: hdl/drd_queue.sv
// Short detection queue between the front end and the box scaler.
// Holds raw detections so each side can stall on its own. Uses drd_pkg.
module drd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  drd_pkg::det_t push_data_i,
  output logic          full_o,
  output logic          valid_o,
  output drd_pkg::det_t pop_data_o,
  input  logic          pop_i
);
  import drd_pkg::*;

  det_t                 entry_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, rd_q;
  logic [QueueCntW-1:0] cnt_q;

  assign full_o = cnt_q == QueueCntW'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign pop_data_o = entry_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (int'(wr_q) == QueueDepth - 1) ? '0 : wr_q + QueuePtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (int'(rd_q) == QueueDepth - 1) ? '0 : rd_q + QueuePtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QueueCntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QueueCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= push_data_i;
    end
  end

endmodule

// File: hdl/drd_back.sv
// Back end: scales box edges in two stages and holds the result register.
// Multiplies in the first stage, truncates and saturates in the second. Uses drd_pkg.
module drd_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  drd_pkg::scale_cfg_t               scale_i,
  input  logic                              q_valid_i,
  input  drd_pkg::det_t                     q_data_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [drd_pkg::ClassW-1:0]        out_class_index_o,
  output logic [drd_pkg::ValueW-1:0]        out_confidence_o,
  output logic signed [drd_pkg::ValueW:0]   out_box_left_o,
  output logic signed [drd_pkg::ValueW:0]   out_box_top_o,
  output logic [drd_pkg::ValueW-1:0]        out_box_width_o,
  output logic [drd_pkg::ValueW-1:0]        out_box_height_o
);
  import drd_pkg::*;

  localparam int EdgeW = ValueW + 2;
  localparam int EdgeProdW = EdgeW + ScaleW + 1;
  localparam int SizeProdW = ValueW + ScaleW;

  function automatic logic signed [ValueW:0] sat_edge(input logic signed [EdgeProdW-1:0] p);
    logic signed [EdgeProdW-1:0] adj;
    logic signed [EdgeProdW-6:0] q;
    adj = p + (p[EdgeProdW-1] ? EdgeProdW'(31) : EdgeProdW'(0));
    q = adj[EdgeProdW-1:5];
    if (q < -(EdgeProdW-5)'(65536)) begin
      return -(ValueW+1)'(65536);
    end else if (q > (EdgeProdW-5)'(65535)) begin
      return (ValueW+1)'(65535);
    end
    return q[ValueW:0];
  endfunction

  function automatic logic [ValueW-1:0] sat_size(input logic [SizeProdW-1:0] p);
    logic [SizeProdW-5:0] q;
    q = p[SizeProdW-1:4];
    return (q > (SizeProdW-4)'(65535)) ? {ValueW{1'b1}} : q[ValueW-1:0];
  endfunction

  logic                        s1_valid_q;
  logic [ClassW-1:0]           s1_class_q;
  logic [ValueW-1:0]           s1_conf_q;
  logic signed [EdgeProdW-1:0] s1_left_q, s1_top_q;
  logic [SizeProdW-1:0]        s1_width_q, s1_height_q;
  logic signed [EdgeW-1:0]     dx, dy;
  logic signed [EdgeProdW-1:0] left_p, top_p;
  logic                        s2_ready, s1_ready;

  assign s2_ready = !out_valid_o || !out_stall_i;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign pop_o = q_valid_i && s1_ready;

  always_comb begin
    dx = $signed({1'b0, q_data_i.x, 1'b0}) - $signed({2'b00, q_data_i.w});
    dy = $signed({1'b0, q_data_i.y, 1'b0}) - $signed({2'b00, q_data_i.h});
    left_p = dx * $signed({1'b0, scale_i.x_scale});
    top_p = dy * $signed({1'b0, scale_i.y_scale});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= q_valid_i;
      end
      if (s2_ready) begin
        out_valid_o <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_class_q <= q_data_i.class_index;
      s1_conf_q <= q_data_i.confidence;
      s1_left_q <= left_p;
      s1_top_q <= top_p;
      s1_width_q <= q_data_i.w * scale_i.x_scale;
      s1_height_q <= q_data_i.h * scale_i.y_scale;
    end
    if (s2_ready && s1_valid_q) begin
      out_class_index_o <= s1_class_q;
      out_confidence_o <= s1_conf_q;
      out_box_left_o <= sat_edge(s1_left_q);
      out_box_top_o <= sat_edge(s1_top_q);
      out_box_width_o <= sat_size(s1_width_q);
      out_box_height_o <= sat_size(s1_height_q);
    end
  end

endmodule

// File: hdl/drd_checker.sv
// Port-level checker of the detection row decoder, bound to the top level.
// Uses drd_pkg and the macros of detection_row_decode_core_defines.svh.
`include "detection_row_decode_core_defines.svh"

module drd_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic [drd_pkg::ValueW-1:0]        in_element_value_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [drd_pkg::ClassW-1:0]        out_class_index_o,
  input logic [drd_pkg::ValueW-1:0]        out_confidence_o,
  input logic signed [drd_pkg::ValueW:0]   out_box_left_o,
  input logic signed [drd_pkg::ValueW:0]   out_box_top_o,
  input logic [drd_pkg::ValueW-1:0]        out_box_width_o,
  input logic [drd_pkg::ValueW-1:0]        out_box_height_o
);
  import drd_pkg::*;

  logic                            in_waiting;
  logic                            out_waiting;
  logic [ClassW+5*ValueW+1:0]      out_payload;

  assign in_waiting = in_valid_i && in_stall_o;
  assign out_waiting = out_valid_o && out_stall_i;
  assign out_payload = {out_class_index_o, out_confidence_o, out_box_left_o, out_box_top_o,
                        out_box_width_o, out_box_height_o};

  `DRD_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_waiting, in_valid_i && $stable(in_element_value_i))
  `DRD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_waiting, out_valid_o && $stable(out_payload))
  `DRD_ASSERT_IMPLY(a_stall_needs_result, clk_i, rst_ni, in_stall_o, out_valid_o)
  `DRD_ASSERT_IMPLY(a_stall_after_out_stall, clk_i, rst_ni, in_stall_o, $past(out_waiting))

endmodule

bind detection_row_decode_core drd_checker u_drd_checker (.*);
